FILE: src/mrse_pkg.sv
`default_nettype none
package mrse_pkg;

	localparam int KEY_W     = 32;
	localparam int PAYLOAD_W = 32;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;
	typedef logic       kind_t;

	localparam op_t OP_LOAD  = 2'd0;
	localparam op_t OP_PLACE = 2'd1;
	localparam op_t OP_FLUSH = 2'd2;
	localparam op_t OP_CLEAR = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_EMPTY     = 2'd3;

	localparam kind_t KIND_ACK   = 1'b0;
	localparam kind_t KIND_ENTRY = 1'b1;

	typedef struct packed {
		op_t                  operation;
		logic [KEY_W-1:0]     key;
		logic [PAYLOAD_W-1:0] payload;
	} req_item_t;

	typedef struct packed {
		kind_t                kind;
		logic [PAYLOAD_W-1:0] payload_out;
		status_t              status;
		logic                 last;
	} rsp_item_t;

endpackage
`default_nettype wire

FILE: src/mrse_req_if.sv
`default_nettype none
interface mrse_req_if;
	logic                valid;
	logic                ready;
	mrse_pkg::req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/mrse_rsp_if.sv
`default_nettype none
interface mrse_rsp_if;
	logic                valid;
	logic                ready;
	mrse_pkg::rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/mrse_ram.sv
`default_nettype none
module mrse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic                 we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]     wdata,
	output logic      [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: src/memo_rank_sort_engine_core.sv
// load and clear: the result is sent from the ack state once the output is free
// place: the key memory is read one entry per cycle until a key matches or all are read
// flush: marked payloads go one by one through the single payload memory port
// one item at a time: req.ready is high only while the sequencer is idle
// reset clears the entry count, the marks and the output register; the memories are not cleared
`default_nettype none
module memo_rank_sort_engine_core #(
	parameter int TABLE_DEPTH  = 64,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mrse_req_if.sink  req,
	mrse_rsp_if.source rsp
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ACK   = 3'd1;
	localparam logic [2:0] S_PSCAN = 3'd2;
	localparam logic [2:0] S_FSCAN = 3'd3;
	localparam logic [2:0] S_FREAD = 3'd4;
	localparam logic [2:0] S_FEND  = 3'd5;

	logic [2:0]                state_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic [TABLE_DEPTH-1:0]    marked_q;
	logic                      cmp_valid_s1;
	logic [AW-1:0]             cmp_idx_s1;
	logic [KEY_BITS-1:0]       key_q;
	logic [PAYLOAD_BITS-1:0]   payload_q;
	logic [PAYLOAD_BITS-1:0]   held_q;
	logic                      have_q;
	mrse_pkg::status_t         ack_status_q;
	logic                      rsp_valid_q;
	mrse_pkg::rsp_item_t       rsp_data_q;

	logic [KEY_BITS-1:0]       key_in;
	logic [PAYLOAD_BITS-1:0]   payload_in;
	logic [mrse_pkg::PAYLOAD_W-1:0] held_out;
	logic [KEY_BITS-1:0]       key_rd;
	logic [PAYLOAD_BITS-1:0]   pay_rd;
	logic                      key_en;
	logic                      key_we;
	logic [AW-1:0]             key_addr;
	logic                      pay_en;
	logic                      pay_we;
	logic [AW-1:0]             pay_addr;
	logic                      rsp_free;
	logic                      rsp_load;
	logic                      found;
	logic                      table_full;

	// width fitting between the fixed item fields and the stored widths
	generate
		if (KEY_BITS > mrse_pkg::KEY_W) begin : g_key_wide
			assign key_in = {{(KEY_BITS - mrse_pkg::KEY_W){1'b0}}, req.data.key};
		end else if (KEY_BITS == mrse_pkg::KEY_W) begin : g_key_same
			assign key_in = req.data.key;
		end else begin : g_key_narrow
			assign key_in = req.data.key[KEY_BITS-1:0];
		end
		if (PAYLOAD_BITS > mrse_pkg::PAYLOAD_W) begin : g_pay_wide
			assign payload_in = {{(PAYLOAD_BITS - mrse_pkg::PAYLOAD_W){1'b0}},
				req.data.payload};
			assign held_out   = held_q[mrse_pkg::PAYLOAD_W-1:0];
		end else if (PAYLOAD_BITS == mrse_pkg::PAYLOAD_W) begin : g_pay_same
			assign payload_in = req.data.payload;
			assign held_out   = held_q;
		end else begin : g_pay_narrow
			assign payload_in = req.data.payload[PAYLOAD_BITS-1:0];
			assign held_out   = {{(mrse_pkg::PAYLOAD_W - PAYLOAD_BITS){1'b0}}, held_q};
		end
	endgenerate

	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign rsp_load   = rsp_free && ((state_q == S_ACK) || (state_q == S_FEND) ||
		(state_q == S_FREAD && have_q));
	assign found      = cmp_valid_s1 && (key_rd == key_q);
	assign table_full = (count_q >= CW'(TABLE_DEPTH));

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_comb begin
		key_en   = 1'b0;
		key_we   = 1'b0;
		key_addr = idx_q[AW-1:0];
		pay_en   = 1'b0;
		pay_we   = 1'b0;
		pay_addr = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && req.data.operation == mrse_pkg::OP_LOAD && !table_full) begin
					key_en   = 1'b1;
					key_we   = 1'b1;
					key_addr = count_q[AW-1:0];
				end
			end
			S_PSCAN: begin
				if (found) begin
					pay_en   = 1'b1;
					pay_we   = 1'b1;
					pay_addr = cmp_idx_s1;
				end else if (idx_q != count_q) begin
					key_en = 1'b1;
				end
			end
			S_FSCAN: begin
				if (idx_q != count_q && marked_q[idx_q[AW-1:0]]) begin
					pay_en = 1'b1;
				end
			end
			S_ACK, S_FREAD, S_FEND: begin
			end
			default: begin
			end
		endcase
	end

	mrse_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.en    (key_en),
		.we    (key_we),
		.addr  (key_addr),
		.wdata (key_in),
		.rdata (key_rd)
	);

	mrse_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_pay_ram (
		.clk   (clk),
		.en    (pay_en),
		.we    (pay_we),
		.addr  (pay_addr),
		.wdata (payload_q),
		.rdata (pay_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			marked_q     <= '0;
			cmp_valid_s1 <= 1'b0;
			cmp_idx_s1   <= '0;
			key_q        <= '0;
			payload_q    <= '0;
			held_q       <= '0;
			have_q       <= 1'b0;
			ack_status_q <= mrse_pkg::ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_data_q   <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						unique case (req.data.operation)
							mrse_pkg::OP_LOAD: begin
								if (table_full) begin
									ack_status_q <= mrse_pkg::ST_FULL;
								end else begin
									count_q                    <= count_q + 1'b1;
									marked_q[count_q[AW-1:0]]  <= 1'b0;
									ack_status_q               <= mrse_pkg::ST_OK;
								end
								state_q <= S_ACK;
							end
							mrse_pkg::OP_PLACE: begin
								key_q        <= key_in;
								payload_q    <= payload_in;
								idx_q        <= '0;
								cmp_valid_s1 <= 1'b0;
								state_q      <= S_PSCAN;
							end
							mrse_pkg::OP_FLUSH: begin
								idx_q   <= '0;
								have_q  <= 1'b0;
								state_q <= S_FSCAN;
							end
							mrse_pkg::OP_CLEAR: begin
								count_q      <= '0;
								marked_q     <= '0;
								ack_status_q <= mrse_pkg::ST_OK;
								state_q      <= S_ACK;
							end
							default: begin
							end
						endcase
					end
				end
				S_ACK: begin
					if (rsp_free) begin
						rsp_data_q  <= '{kind: mrse_pkg::KIND_ACK, payload_out: '0,
							status: ack_status_q, last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_PSCAN: begin
					// key read for idx_q goes out while the previous entry is compared
					if (found) begin
						marked_q[cmp_idx_s1] <= 1'b1;
						ack_status_q         <= mrse_pkg::ST_OK;
						state_q              <= S_ACK;
					end else if (idx_q == count_q) begin
						cmp_valid_s1 <= 1'b0;
						if (!cmp_valid_s1) begin
							ack_status_q <= mrse_pkg::ST_NOT_FOUND;
							state_q      <= S_ACK;
						end
					end else begin
						cmp_valid_s1 <= 1'b1;
						cmp_idx_s1   <= idx_q[AW-1:0];
						idx_q        <= idx_q + 1'b1;
					end
				end
				S_FSCAN: begin
					if (idx_q == count_q) begin
						state_q <= S_FEND;
					end else if (marked_q[idx_q[AW-1:0]]) begin
						state_q <= S_FREAD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FREAD: begin
					// hold one entry back so the final one can carry last
					if (!have_q || rsp_free) begin
						if (have_q) begin
							rsp_data_q  <= '{kind: mrse_pkg::KIND_ENTRY, payload_out: held_out,
								status: mrse_pkg::ST_OK, last: 1'b0};
						end
						held_q  <= pay_rd;
						have_q  <= 1'b1;
						idx_q   <= idx_q + 1'b1;
						state_q <= S_FSCAN;
					end
				end
				S_FEND: begin
					if (rsp_free) begin
						if (have_q) begin
							rsp_data_q <= '{kind: mrse_pkg::KIND_ENTRY, payload_out: held_out,
								status: mrse_pkg::ST_OK, last: 1'b1};
						end else begin
							rsp_data_q <= '{kind: mrse_pkg::KIND_ACK, payload_out: '0,
								status: mrse_pkg::ST_EMPTY, last: 1'b1};
						end
						marked_q <= '0;
						have_q   <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
